@@ rtl/core/sed_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String escape decoder package
// Shared types, character codes and decode helpers for the string literal
// escape decoder with UTF-8 output.
// ----------------------------------------------------------------------------
package sed_pkg;

  typedef enum logic [5:0] {
    MODE_PLAIN  = 6'b000001,
    MODE_BSLASH = 6'b000010,
    MODE_HEX2   = 6'b000100,
    MODE_HEX4   = 6'b001000,
    MODE_HEX8   = 6'b010000,
    MODE_DEC    = 6'b100000
  } mode_e;

  typedef enum logic [2:0] {
    KIND_DATA       = 3'd0,
    KIND_BAD_ESCAPE = 3'd1,
    KIND_TOO_LARGE  = 3'd2,
    KIND_CLOSED     = 3'd3,
    KIND_UNTERM     = 3'd4
  } kind_e;

  localparam int unsigned MaxResults = 5;

  localparam logic [7:0] ChrNul    = 8'h00;
  localparam logic [7:0] ChrQuote  = 8'h22;
  localparam logic [7:0] ChrBslash = 8'h5C;
  localparam logic [7:0] ChrZero   = 8'h30;
  localparam logic [7:0] ChrNine   = 8'h39;
  localparam logic [7:0] ChrLowX   = 8'h78;
  localparam logic [7:0] ChrUpX    = 8'h58;
  localparam logic [7:0] ChrLowU   = 8'h75;
  localparam logic [7:0] ChrUpU    = 8'h55;

  localparam logic [31:0] MaxCodePoint = 32'd2097151;
  localparam logic [31:0] MaxThreeByte = 32'd65535;
  localparam logic [31:0] MaxTwoByte   = 32'd2047;
  localparam logic [31:0] MaxRawByte   = 32'd255;

  localparam logic [7:0] Lead4 = 8'd240;
  localparam logic [7:0] Lead3 = 8'd224;
  localparam logic [7:0] Lead2 = 8'd192;
  localparam logic [7:0] Cont  = 8'd128;

  localparam logic [3:0] DigitsHex2 = 4'd2;
  localparam logic [3:0] DigitsHex4 = 4'd4;
  localparam logic [3:0] DigitsHex8 = 4'd8;
  localparam logic [3:0] DigitsDec  = 4'd3;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h61 + 8'd10)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h41 + 8'd10)};
    end
    return r;
  endfunction

  function automatic logic [7:0] named_escape(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    unique case (b)
      8'h61:   r = 8'd7;
      8'h62:   r = 8'd8;
      8'h65:   r = 8'd27;
      8'h66:   r = 8'd12;
      8'h6E:   r = 8'd10;
      8'h72:   r = 8'd13;
      8'h74:   r = 8'd9;
      8'h76:   r = 8'd11;
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/string_escape_utf8_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String escape decoder with UTF-8 output
// Decodes a string literal body byte by byte into data bytes and events.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  input     in_valid_i / in_ready_o   source_byte_i
//  output    out_valid_o / out_ready_i kind_o, out_byte_o, last_o
//
//  An input byte is decoded in the cycle it is transferred; its 0 to 5
//  results land in a result buffer and leave one per cycle unless stalled.
//  A byte with at most one result sustains one transfer per cycle unless
//  stalled; with more results, the input waits for the last one to leave.
//  Reset returns the decoder to plain text and empties the result buffer.
//  A stalled output holds the buffer and the input waits for its last entry.
// ----------------------------------------------------------------------------
module string_escape_utf8_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] source_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);
  import sed_pkg::*;

  mode_e       mode_q, mode_d;
  logic [31:0] value_q, value_d;
  logic [3:0]  count_q, count_d;

  kind_e       buf_kind_q [MaxResults];
  logic [7:0]  buf_byte_q [MaxResults];
  logic [2:0]  num_q;
  logic [2:0]  head_q;

  kind_e       res_kind [MaxResults];
  logic [7:0]  res_byte [MaxResults];
  logic [2:0]  res_num;

  logic [7:0]  b;
  logic [4:0]  hex;
  logic        is_dec;
  logic [3:0]  max_digits;
  logic [3:0]  count_inc;
  logic [31:0] hex_next;
  logic [31:0] dec_next;
  logic        fin;
  logic [31:0] fin_val;
  logic        do_plain;
  logic        bad;
  logic        bad_eot;
  logic        named_put;
  logic        in_fire;
  logic        out_fire;
  logic        out_last;

  assign b         = source_byte_i;
  assign hex       = hex_value(b);
  assign is_dec    = (b >= ChrZero) && (b <= ChrNine);
  assign count_inc = count_q + 4'd1;
  assign hex_next  = {value_q[27:0], hex[3:0]};
  assign dec_next  = (value_q << 3) + (value_q << 1) + {24'd0, b - ChrZero};

  always_comb begin
    unique case (mode_q)
      MODE_HEX2: max_digits = DigitsHex2;
      MODE_HEX4: max_digits = DigitsHex4;
      MODE_HEX8: max_digits = DigitsHex8;
      default:   max_digits = DigitsDec;
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    value_d   = value_q;
    count_d   = count_q;
    fin       = 1'b0;
    fin_val   = value_q;
    do_plain  = 1'b0;
    bad       = 1'b0;
    bad_eot   = 1'b0;
    named_put = 1'b0;
    res_num   = 3'd0;
    for (int k = 0; k < MaxResults; k++) begin
      res_kind[k] = KIND_DATA;
      res_byte[k] = 8'd0;
    end

    unique case (mode_q)
      MODE_BSLASH: begin
        mode_d  = MODE_PLAIN;
        value_d = 32'd0;
        count_d = 4'd0;
        if (b == ChrNul) begin
          bad     = 1'b1;
          bad_eot = 1'b1;
        end else if (b == ChrLowX || b == ChrUpX) begin
          mode_d = MODE_HEX2;
        end else if (b == ChrLowU) begin
          mode_d = MODE_HEX4;
        end else if (b == ChrUpU) begin
          mode_d = MODE_HEX8;
        end else if (is_dec) begin
          mode_d  = MODE_DEC;
          value_d = {24'd0, b - ChrZero};
          count_d = 4'd1;
        end else begin
          named_put = 1'b1;
        end
      end
      MODE_HEX2, MODE_HEX4, MODE_HEX8: begin
        if (hex[4]) begin
          value_d = hex_next;
          count_d = count_inc;
          if (count_inc >= max_digits) begin
            fin     = 1'b1;
            fin_val = hex_next;
          end
        end else if (count_q == 4'd0) begin
          bad     = 1'b1;
          bad_eot = (b == ChrNul);
          mode_d  = MODE_PLAIN;
          value_d = 32'd0;
          count_d = 4'd0;
        end else begin
          fin      = 1'b1;
          do_plain = 1'b1;
        end
      end
      MODE_DEC: begin
        if (is_dec) begin
          value_d = dec_next;
          count_d = count_inc;
          if (count_inc >= max_digits) begin
            fin     = 1'b1;
            fin_val = dec_next;
          end
        end else begin
          fin      = 1'b1;
          do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    if (fin) begin
      mode_d  = MODE_PLAIN;
      value_d = 32'd0;
      count_d = 4'd0;
      if ((mode_q == MODE_HEX8 && fin_val > MaxCodePoint) ||
          (mode_q == MODE_DEC && fin_val > MaxRawByte)) begin
        res_kind[res_num] = KIND_TOO_LARGE;
        res_num = res_num + 3'd1;
      end else if (fin_val <= MaxRawByte) begin
        res_byte[res_num] = fin_val[7:0];
        res_num = res_num + 3'd1;
      end else if (fin_val > MaxThreeByte) begin
        res_byte[res_num] = {5'd0, fin_val[20:18]} | Lead4;
        res_num = res_num + 3'd1;
        res_byte[res_num] = {2'd0, fin_val[17:12]} | Cont;
        res_num = res_num + 3'd1;
        res_byte[res_num] = {2'd0, fin_val[11:6]} | Cont;
        res_num = res_num + 3'd1;
        res_byte[res_num] = {2'd0, fin_val[5:0]} | Cont;
        res_num = res_num + 3'd1;
      end else if (fin_val > MaxTwoByte) begin
        res_byte[res_num] = {4'd0, fin_val[15:12]} | Lead3;
        res_num = res_num + 3'd1;
        res_byte[res_num] = {2'd0, fin_val[11:6]} | Cont;
        res_num = res_num + 3'd1;
        res_byte[res_num] = {2'd0, fin_val[5:0]} | Cont;
        res_num = res_num + 3'd1;
      end else begin
        res_byte[res_num] = {3'd0, fin_val[10:6]} | Lead2;
        res_num = res_num + 3'd1;
        res_byte[res_num] = {2'd0, fin_val[5:0]} | Cont;
        res_num = res_num + 3'd1;
      end
    end

    if (bad) begin
      res_kind[res_num] = KIND_BAD_ESCAPE;
      res_num = res_num + 3'd1;
    end
    if (bad_eot) begin
      res_kind[res_num] = KIND_UNTERM;
      res_num = res_num + 3'd1;
    end
    if (named_put) begin
      res_byte[res_num] = named_escape(b);
      res_num = res_num + 3'd1;
    end

    if (do_plain) begin
      mode_d  = MODE_PLAIN;
      value_d = 32'd0;
      count_d = 4'd0;
      if (b == ChrQuote) begin
        res_kind[res_num] = KIND_CLOSED;
        res_num = res_num + 3'd1;
      end else if (b == ChrNul) begin
        res_kind[res_num] = KIND_UNTERM;
        res_num = res_num + 3'd1;
      end else if (b == ChrBslash) begin
        mode_d = MODE_BSLASH;
      end else begin
        res_byte[res_num] = b;
        res_num = res_num + 3'd1;
      end
    end
  end

  assign out_valid_o = (head_q != num_q);
  assign out_last    = ((head_q + 3'd1) == num_q);
  assign out_fire    = out_valid_o && out_ready_i;
  assign in_ready_o  = !out_valid_o || (out_ready_i && out_last);
  assign in_fire     = in_valid_i && in_ready_o;

  assign kind_o     = buf_kind_q[head_q];
  assign out_byte_o = buf_byte_q[head_q];
  assign last_o     = out_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_PLAIN;
      value_q <= 32'd0;
      count_q <= 4'd0;
      num_q   <= 3'd0;
      head_q  <= 3'd0;
    end else if (in_fire) begin
      mode_q  <= mode_d;
      value_q <= value_d;
      count_q <= count_d;
      num_q   <= res_num;
      head_q  <= 3'd0;
    end else if (out_fire) begin
      head_q <= head_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int k = 0; k < MaxResults; k++) begin
        buf_kind_q[k] <= res_kind[k];
        buf_byte_q[k] <= res_byte[k];
      end
    end
  end

endmodule
